[design/scl_pkg.sv]
`default_nettype none
package scl_pkg;
    localparam int MAX_N  = 64;
    localparam int IDX_W  = $clog2(MAX_N);
    localparam int SIZE_W = IDX_W + 1;
    localparam int DEPTH  = MAX_N * MAX_N;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DATA_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] CFG_SIZE = 2'd0;
    localparam logic [1:0] CFG_MODE = 2'd1;

    localparam logic [1:0] MODE_MIN_PLUS  = 2'd0;
    localparam logic [1:0] MODE_MAX_PLUS  = 2'd1;
    localparam logic [1:0] MODE_MAX_TIMES = 2'd2;
    localparam logic [1:0] MODE_MIN_TIMES = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              err;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0] n_live;
        logic [1:0]        mode;
    } cfg_t;
endpackage
`default_nettype wire

[design/semiring_closure_engine.sv]
// An in-range write updates the matrix; the result register is set from the queue head;
// a read passes through S_RDW to it. Close: S_ARD, S_AWT per (k,i) row start,
// then S_JRD, S_JMUL, S_JCMP per relaxation on the matrix RAM (read-compute-write).
// One item at a time leaves the queue, in S_IDLE; a 4-entry queue decouples input.
// Reset (aresetn, synchronous, low) clears control state, size 64, mode min-plus;
// matrix contents are undefined until written.
`default_nettype none
module semiring_closure_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [5:0]         s_row,
    input  wire logic [5:0]         s_col,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_value,
    output logic                    m_index_error
);
    import scl_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [1:0]        mode_reg;
    cfg_t              cfg;
    cmd_t              cmd;
    logic              cmd_valid, cmd_pop;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(MAX_N);
            mode_reg <= MODE_MIN_PLUS;
        end else if (cfg_we) begin
            if (cfg_index == CFG_SIZE) size_reg <= cfg_wdata;
            if (cfg_index == CFG_MODE) mode_reg <= cfg_wdata[1:0];
        end
    end

    // saturate size to the matrix capacity
    assign cfg.n_live = (size_reg > SIZE_W'(MAX_N)) ? SIZE_W'(MAX_N) : size_reg;
    assign cfg.mode   = mode_reg;

    scl_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_row(s_row), .s_col(s_col), .s_value(s_value),
        .cfg(cfg), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
    );

    scl_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cfg(cfg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_read_value(m_read_value), .m_index_error(m_index_error)
    );
endmodule
`default_nettype wire

[design/scl_ram.sv]
`default_nettype none
module scl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write one word, read two words with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end
endmodule
`default_nettype wire

[design/scl_front.sv]
`default_nettype none
module scl_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_operation,
    input  wire logic [5:0]           s_row,
    input  wire logic [5:0]           s_col,
    input  wire logic signed [31:0]   s_value,
    input  wire scl_pkg::cfg_t        cfg,
    output scl_pkg::cmd_t             cmd,
    output logic                      cmd_valid,
    input  wire logic                 cmd_pop
);
    import scl_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    logic              in_range;
    cmd_t              entry;

    // classify the item: flag out-of-range writes and reads
    always_comb begin
        in_range    = ({1'b0, s_row} < cfg.n_live) && ({1'b0, s_col} < cfg.n_live);
        entry.op    = s_operation;
        entry.row   = s_row;
        entry.col   = s_col;
        entry.value = s_value;
        entry.err   = ((s_operation == OP_WRITE) || (s_operation == OP_READ)) && !in_range;
    end

    assign s_ready   = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rptr_reg];

    // advance queue pointers
    always_comb begin
        wptr_next = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = cmd_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // store the classified item
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= entry;
        end
    end
endmodule
`default_nettype wire

[design/scl_back.sv]
`default_nettype none
module scl_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire scl_pkg::cmd_t      cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_pop,
    input  wire scl_pkg::cfg_t      cfg,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_read_value,
    output logic                    m_index_error
);
    import scl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDW   = 8'b0000_0010,
        S_ARD   = 8'b0000_0100,
        S_AWT   = 8'b0000_1000,
        S_JRD   = 8'b0001_0000,
        S_JMUL  = 8'b0010_0000,
        S_JCMP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic               mul_reg, mul_next, max_reg, max_next;
    logic [DATA_W-1:0]  a_reg, a_next, cand_reg, cand_next, cur_reg, cur_next;
    logic               vld_reg, vld_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic               err_reg, err_next;
    logic               out_free;
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr0, raddr1;
    logic [DATA_W-1:0]  wdata, rdata0, rdata1;
    logic               better;

    scl_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    assign out_free      = !vld_reg || m_ready;
    assign m_valid       = vld_reg;
    assign m_read_value  = val_reg;
    assign m_index_error = err_reg;
    assign better = max_reg ? ($signed(cand_reg) > $signed(cur_reg))
                            : ($signed(cand_reg) < $signed(cur_reg));

    // sequence items and the closure loop
    always_comb begin
        state_next = state_reg;
        k_next = k_reg; i_next = i_reg; j_next = j_reg;
        last_next = last_reg; mul_next = mul_reg; max_next = max_reg;
        a_next = a_reg; cand_next = cand_reg; cur_next = cur_reg;
        vld_next = vld_reg && !m_ready;
        val_next = val_reg; err_next = err_reg;
        cmd_pop = 1'b0;
        we = 1'b0; waddr = {cmd.row, cmd.col}; wdata = cmd.value;
        raddr0 = {cmd.row, cmd.col}; raddr1 = {i_reg, j_reg};
        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_WRITE: begin
                            we = !cmd.err;
                            vld_next = 1'b1; val_next = '0; err_next = cmd.err;
                        end
                        OP_READ: begin
                            if (cmd.err) begin
                                vld_next = 1'b1; val_next = '0; err_next = 1'b1;
                            end else begin
                                state_next = S_RDW;
                            end
                        end
                        OP_CLOSE: begin
                            last_next = IDX_W'(cfg.n_live - SIZE_W'(1));
                            mul_next  = (cfg.mode == MODE_MAX_TIMES) ||
                                        (cfg.mode == MODE_MIN_TIMES);
                            max_next  = (cfg.mode == MODE_MAX_PLUS) ||
                                        (cfg.mode == MODE_MAX_TIMES);
                            k_next = '0; i_next = '0;
                            if (cfg.n_live == '0) begin
                                vld_next = 1'b1; val_next = '0; err_next = 1'b0;
                            end else begin
                                state_next = S_ARD;
                            end
                        end
                        default: begin
                            vld_next = 1'b1; val_next = '0; err_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RDW: begin
                vld_next = 1'b1; val_next = rdata0; err_next = 1'b0;
                state_next = S_IDLE;
            end
            S_ARD: begin
                raddr0 = {i_reg, k_reg};
                state_next = S_AWT;
            end
            S_AWT: begin
                a_next = rdata0; j_next = '0;
                state_next = S_JRD;
            end
            S_JRD: begin
                raddr0 = {k_reg, j_reg};
                raddr1 = {i_reg, j_reg};
                state_next = S_JMUL;
            end
            S_JMUL: begin
                cand_next = mul_reg ? DATA_W'(a_reg * rdata0) : a_reg + rdata0;
                cur_next  = rdata1;
                state_next = S_JCMP;
            end
            S_JCMP: begin
                we = better; waddr = {i_reg, j_reg}; wdata = cand_reg;
                if (j_reg != last_reg) begin
                    j_next = j_reg + IDX_W'(1); state_next = S_JRD;
                end else if (i_reg != last_reg) begin
                    i_next = i_reg + IDX_W'(1); state_next = S_ARD;
                end else if (k_reg != last_reg) begin
                    k_next = k_reg + IDX_W'(1); i_next = '0; state_next = S_ARD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                vld_next = 1'b1; val_next = '0; err_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next; i_reg <= i_next; j_reg <= j_next;
        last_reg <= last_next; mul_reg <= mul_next; max_reg <= max_next;
        a_reg <= a_next; cand_reg <= cand_next; cur_reg <= cur_next;
        val_reg <= val_next; err_reg <= err_next;
    end

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (state_reg == S_IDLE) && out_free)
        else $error("item taken while busy or output full");
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg == S_IDLE) || (state_reg == S_JCMP))
        else $error("matrix write outside write or relax step");
    a_done_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) || (state_reg == S_RDW)) |-> !vld_reg || m_ready)
        else $error("result slot busy at completion");
endmodule
`default_nettype wire

[tb/scl_checker.sv]
`timescale 1ns / 100ps
module scl_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [5:0]         s_row,
    input  wire logic [5:0]         s_col,
    input  wire logic signed [31:0] s_value,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_read_value,
    input  wire logic               m_index_error,
    output int                      fail_count,
    output int                      answers_pending
);
    import scl_pkg::*;

    typedef struct {
        logic signed [31:0] read_value;
        logic               index_error;
    } answer_t;

    answer_t            answer_q[$];
    logic signed [31:0] dist_mat [DEPTH];
    logic [6:0]         size_reg;
    logic [1:0]         mode_reg;

    initial begin
        fail_count      = 0;
        answers_pending = 0;
    end

    function automatic int live_n();
        return (size_reg > MAX_N) ? MAX_N : int'(size_reg);
    endfunction

    // Relax every entry through every pivot, k outermost
    task automatic close_matrix();
        int                 n;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] cand;
        logic signed [31:0] cur;
        logic               use_mul;
        logic               want_max;
        n        = live_n();
        use_mul  = (mode_reg == MODE_MAX_TIMES) || (mode_reg == MODE_MIN_TIMES);
        want_max = (mode_reg == MODE_MAX_PLUS) || (mode_reg == MODE_MAX_TIMES);
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                a = dist_mat[i * MAX_N + k];
                for (int j = 0; j < n; j++) begin
                    b    = dist_mat[k * MAX_N + j];
                    cand = use_mul ? a * b : a + b;
                    cur  = dist_mat[i * MAX_N + j];
                    if (want_max ? (cand > cur) : (cand < cur))
                        dist_mat[i * MAX_N + j] = cand;
                end
            end
        end
    endtask

    // Work out the answer one item yields and apply its side effects
    task automatic predict_answer(input logic [1:0] op, input logic [5:0] row,
                                  input logic [5:0] col, input logic signed [31:0] val);
        answer_t ans;
        logic    in_range;
        in_range        = (int'(row) < live_n()) && (int'(col) < live_n());
        ans.read_value  = '0;
        ans.index_error = 1'b0;
        case (op)
            OP_WRITE: begin
                if (in_range)
                    dist_mat[int'(row) * MAX_N + int'(col)] = val;
                else
                    ans.index_error = 1'b1;
            end
            OP_READ: begin
                if (in_range)
                    ans.read_value = dist_mat[int'(row) * MAX_N + int'(col)];
                else
                    ans.index_error = 1'b1;
            end
            OP_CLOSE: close_matrix();
            default: ;
        endcase
        answer_q.push_back(ans);
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            answer_q.delete();
            size_reg = 7'(MAX_N);
            mode_reg = MODE_MIN_PLUS;
        end else begin
            // Compare each result with the oldest answer waiting
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result value=%0d err=%0b",
                             $time, m_read_value, m_index_error);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (m_read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, m_read_value);
                        fail_count++;
                    end
                    if (m_index_error !== want.index_error) begin
                        $display("%0t: index_error expected %0b actual %0b",
                                 $time, want.index_error, m_index_error);
                        fail_count++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_SIZE)
                    size_reg = cfg_wdata;
                else if (cfg_index == CFG_MODE)
                    mode_reg = cfg_wdata[1:0];
            end
            if (s_valid && s_ready)
                predict_answer(s_operation, s_row, s_col, s_value);
        end
        answers_pending <= answer_q.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
    import scl_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic [5:0]         s_row;
    logic [5:0]         s_col;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_read_value;
    logic               m_index_error;
    int                 fail_count;
    int                 answers_pending;

    int   items_sent;
    int   stall_level;
    int   hold_cnt;
    int   cur_n;
    logic written [DEPTH];

    semiring_closure_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_index_error (m_index_error)
    );

    scl_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_index_error   (m_index_error),
        .fail_count      (fail_count),
        .answers_pending (answers_pending)
    );

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_SIZE;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_operation = OP_WRITE;
        s_row       = '0;
        s_col       = '0;
        s_value     = '0;
        m_ready     = 1'b0;
        stall_level = 0;
        hold_cnt    = 0;
        items_sent  = 0;
        foreach (written[i]) written[i] = 1'b0;
    end

    always #6 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (stall_level == 0 || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 2) - 1;
            3, 4: return $urandom_range(0, 18) - 9;
            default: return $urandom;
        endcase
    endfunction

    // Result side: hold ready low for random stretches
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (stall_level != 0 && $urandom_range(0, 9) < 3) begin
            hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [6:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Present one item and hold it until accepted
    task automatic send_item(input logic [1:0] op, input int row, input int col,
                             input logic [31:0] val);
        int gap;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_row       <= row[5:0];
        s_col       <= col[5:0];
        s_value     <= val;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_WRITE && row < cur_n && col < cur_n)
            written[row * MAX_N + col] = 1'b1;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every answer is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_size(input int size);
        cfg_write(CFG_SIZE, size[6:0]);
        cur_n = (size > MAX_N) ? MAX_N : size;
    endtask

    function automatic logic all_written(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!written[i * MAX_N + j]) return 1'b0;
        return 1'b1;
    endfunction

    // One random item at the current size
    task automatic random_item();
        int r;
        int row;
        int col;
        r   = $urandom_range(0, 99);
        row = (cur_n > 0) ? $urandom_range(0, cur_n - 1) : 0;
        col = (cur_n > 0) ? $urandom_range(0, cur_n - 1) : 0;
        if (r < 8 && cur_n <= 8 && all_written(cur_n)) begin
            send_item(OP_CLOSE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        end else if (r < 13) begin
            send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        end else if (r < 25 && cur_n < MAX_N) begin
            // out-of-range row or column
            if ($urandom_range(0, 1))
                row = $urandom_range(cur_n, 63);
            else
                col = $urandom_range(cur_n, 63);
            send_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, row, col, pick_value());
        end else if (cur_n > 0 && r < 60 && written[row * MAX_N + col]) begin
            send_item(OP_READ, row, col, $urandom);
        end else begin
            send_item(OP_WRITE, row, col, pick_value());
        end
    endtask

    initial begin
        int phase;
        int count;
        int size;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 4x4 min-plus with extreme entries
        set_size(4);
        cfg_write(CFG_MODE, 7'(MODE_MIN_PLUS));
        for (int i = 0; i < 16; i++)
            send_item(OP_WRITE, i / 4, i % 4,
                      (i == 1) ? 32'h8000_0000 : (i == 6) ? 32'h7fff_ffff :
                      (i == 11) ? 32'hffff_ffff : i * 3 - 7);
        send_item(OP_READ, 0, 1, 32'h0);
        send_item(OP_WRITE, 4, 0, 32'h1234_5678);
        send_item(OP_READ, 0, 63, 32'h0);
        send_item(OP_NONE, 63, 63, 32'hffff_ffff);
        send_item(OP_CLOSE, 0, 0, 32'h0);
        send_item(OP_READ, 3, 3, 32'h0);
        send_item(OP_READ, 0, 0, 32'h0);
        drain();

        // Random phases over sizes and semirings
        phase = 1;
        while (items_sent < 1050) begin
            case (phase % 10)
                3: size = 64;
                5: size = 1;
                6: size = 0;
                9: size = 127;
                default: size = $urandom_range(2, 8);
            endcase
            stall_level = (phase % 3 == 0) ? 0 : 1;
            set_size(size);
            cfg_write(CFG_MODE, 7'((phase < 8) ? phase % 4 : $urandom_range(0, 3)));
            if (cur_n <= 8)
                for (int i = 0; i < cur_n * cur_n; i++)
                    send_item(OP_WRITE, i / cur_n, i % cur_n, pick_value());
            count = $urandom_range(30, 60);
            for (int i = 0; i < count; i++)
                random_item();
            drain();
            phase++;
        end

        if (fail_count == 0 && answers_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
